// ===== hdl/battery_voltage_gauge_assert.svh =====
// Assertion macros for the battery voltage gauge.
`ifndef BATTERY_VOLTAGE_GAUGE_ASSERT_SVH
`define BATTERY_VOLTAGE_GAUGE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BVG_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BVG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bvg_pkg.sv =====
// Types, constants and microcode program of the battery voltage gauge.
package bvg_pkg;

  localparam int SCALE_W = 12;
  localparam int USB_W   = 14;
  localparam int CFG_W   = 14;
  localparam int RAW_W   = 12;
  localparam int MV_W    = 14;
  localparam int PCT_W   = 7;
  localparam int SV_W    = 22;
  localparam int SP_W    = 15;
  localparam int VQ8_W   = 21;
  localparam int T_W     = 12;
  localparam int SEG_W   = 4;
  localparam int ACC_W   = 38;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 64;
  localparam int UVX_W   = 29;
  localparam int NSEG    = 10;

  localparam logic [SCALE_W-1:0] SCALE_RST = 12'd2579;
  localparam logic [USB_W-1:0]   USB_RST   = 14'd4500;

  // register indexes
  localparam logic [0:0] CFG_IDX_SCALE = 1'b0;
  localparam logic [0:0] CFG_IDX_USB   = 1'b1;

  // range checks (microvolts) and seeding
  localparam int ADC_MIN = 10;
  localparam logic [UVX_W-1:0] UV_MIN     = 29'd500000;
  localparam logic [UVX_W-1:0] UV_MAX     = 29'd6500000;
  localparam logic [UVX_W-1:0] UV_SAT     = 29'd16383500;
  localparam logic [UVX_W-1:0] UV_RND     = 29'd500;
  localparam logic [30:0]      UVQ8_RND   = 31'd500;
  localparam logic [SV_W-1:0]  SV_SEED_MAX = 22'd25;

  // reciprocals of 1000: floor(x/1000) = (x*R) >> K, exact over the used range
  localparam logic [MUL_W-1:0] RCP_MV = 32'd17179870;    // K = 34, x < 2^24
  localparam logic [MUL_W-1:0] RCP_Q8 = 32'd2199023256;  // K = 41, x < 2^31

  // filter coefficients, Q16
  localparam logic [MUL_W-1:0] VA_OLD    = 32'd55706;
  localparam logic [MUL_W-1:0] VA_NEW    = 32'd9830;
  localparam logic [MUL_W-1:0] PA_OLD    = 32'd58982;
  localparam logic [MUL_W-1:0] PA_NEW_Q8 = 32'd1677824;  // 6554 * 256
  localparam logic [ACC_W-1:0] ACC_RND   = 38'd32768;

  localparam logic [MV_W-1:0]  MV_MAX    = 14'd16383;
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;
  localparam logic [12:0]      MV_FULL   = 13'd4200;
  localparam logic [12:0]      MV_EMPTY  = 13'd3350;

  // Li-ion curve, one entry per segment (upper knot is previous segment's lower)
  localparam logic [12:0] SEG_LO_MV [0:NSEG-1] = '{
    13'd4100, 13'd4000, 13'd3920, 13'd3850, 13'd3790,
    13'd3740, 13'd3680, 13'd3600, 13'd3500, 13'd3350
  };
  localparam logic [PCT_W-1:0] SEG_LO_PC [0:NSEG-1] = '{
    7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd0
  };
  localparam logic [7:0] SEG_SPAN [0:NSEG-1] = '{
    8'd100, 8'd100, 8'd80, 8'd70, 8'd60, 8'd50, 8'd60, 8'd80, 8'd100, 8'd150
  };
  // ceil(2^24 / span)
  localparam logic [18:0] SEG_RCP [0:NSEG-1] = '{
    19'd167773, 19'd167773, 19'd209716, 19'd239675, 19'd279621,
    19'd335545, 19'd279621, 19'd209716, 19'd167773, 19'd111849
  };

  typedef struct packed {
    logic [RAW_W-1:0] raw_adc;
    logic [MV_W-1:0]  voltage_mv;
    logic             reading_valid;
    logic             on_usb_power;
    logic [PCT_W-1:0] percent;
    logic             pct_valid;
  } res_t;

  typedef logic [4:0] pc_t;

  typedef enum logic [3:0] {
    A_NONE, A_ADC, A_MV_X, A_Q8_X, A_SV, A_VQ8, A_T, A_SP, A_RAWP
  } mul_a_t;

  typedef enum logic [2:0] {
    B_SCALE, B_RCP_MV, B_RCP_Q8, B_VA_OLD, B_VA_NEW, B_PA_OLD, B_PA_NEW, B_SEG
  } mul_b_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD_RND, ACC_ADD} acc_op_t;

  typedef enum logic [3:0] {
    LD_NONE, LD_UV, LD_VQ8, LD_SV_ACC, LD_SV_VQ8, LD_T, LD_RAWP, LD_SP_ACC, LD_SP_SEED
  } ld_t;

  typedef enum logic [2:0] {J_NEXT, J_ALWAYS, J_INVALID, J_VSEED, J_USB, J_PSEED} jmp_t;

  typedef enum logic [1:0] {EM_NONE, EM_INVALID, EM_USB, EM_PCT} emit_t;

  typedef struct packed {
    mul_a_t  a;
    mul_b_t  b;
    acc_op_t acc;
    ld_t     ld;
    jmp_t    jmp;
    pc_t     target;
    emit_t   emit;
  } uword_t;

  localparam pc_t PC_START   = 5'd0;
  localparam pc_t PC_SV_SEED = 5'd8;
  localparam pc_t PC_USB_CHK = 5'd9;
  localparam pc_t PC_P_SEED  = 5'd17;
  localparam pc_t PC_PCT_OUT = 5'd18;
  localparam pc_t PC_USB_OUT = 5'd19;
  localparam pc_t PC_INVALID = 5'd20;
  localparam pc_t PC_LAST    = 5'd21;

  function automatic uword_t ucode(input pc_t pc);
    case (pc)
      // scale to microvolts, range check
      5'd0:  ucode = '{A_ADC,  B_SCALE,  ACC_HOLD,     LD_NONE,    J_NEXT,    PC_START,   EM_NONE};
      5'd1:  ucode = '{A_NONE, B_SCALE,  ACC_HOLD,     LD_UV,      J_NEXT,    PC_START,   EM_NONE};
      5'd2:  ucode = '{A_Q8_X, B_RCP_Q8, ACC_HOLD,     LD_NONE,    J_INVALID, PC_INVALID, EM_NONE};
      // voltage filter
      5'd3:  ucode = '{A_NONE, B_SCALE,  ACC_HOLD,     LD_VQ8,     J_VSEED,   PC_SV_SEED, EM_NONE};
      5'd4:  ucode = '{A_SV,   B_VA_OLD, ACC_HOLD,     LD_NONE,    J_NEXT,    PC_START,   EM_NONE};
      5'd5:  ucode = '{A_VQ8,  B_VA_NEW, ACC_LOAD_RND, LD_NONE,    J_NEXT,    PC_START,   EM_NONE};
      5'd6:  ucode = '{A_NONE, B_SCALE,  ACC_ADD,      LD_NONE,    J_NEXT,    PC_START,   EM_NONE};
      5'd7:  ucode = '{A_NONE, B_SCALE,  ACC_HOLD,     LD_SV_ACC,  J_ALWAYS,  PC_USB_CHK, EM_NONE};
      5'd8:  ucode = '{A_NONE, B_SCALE,  ACC_HOLD,     LD_SV_VQ8,  J_NEXT,    PC_START,   EM_NONE};
      5'd9:  ucode = '{A_NONE, B_SCALE,  ACC_HOLD,     LD_NONE,    J_USB,     PC_USB_OUT, EM_NONE};
      // curve lookup
      5'd10: ucode = '{A_NONE, B_SCALE,  ACC_HOLD,     LD_T,       J_NEXT,    PC_START,   EM_NONE};
      5'd11: ucode = '{A_T,    B_SEG,    ACC_HOLD,     LD_NONE,    J_NEXT,    PC_START,   EM_NONE};
      5'd12: ucode = '{A_NONE, B_SCALE,  ACC_HOLD,     LD_RAWP,    J_PSEED,   PC_P_SEED,  EM_NONE};
      // percent filter
      5'd13: ucode = '{A_SP,   B_PA_OLD, ACC_HOLD,     LD_NONE,    J_NEXT,    PC_START,   EM_NONE};
      5'd14: ucode = '{A_RAWP, B_PA_NEW, ACC_LOAD_RND, LD_NONE,    J_NEXT,    PC_START,   EM_NONE};
      5'd15: ucode = '{A_NONE, B_SCALE,  ACC_ADD,      LD_NONE,    J_NEXT,    PC_START,   EM_NONE};
      5'd16: ucode = '{A_NONE, B_SCALE,  ACC_HOLD,     LD_SP_ACC,  J_ALWAYS,  PC_PCT_OUT, EM_NONE};
      5'd17: ucode = '{A_NONE, B_SCALE,  ACC_HOLD,     LD_SP_SEED, J_NEXT,    PC_START,   EM_NONE};
      // results
      5'd18: ucode = '{A_NONE, B_SCALE,  ACC_HOLD,     LD_NONE,    J_NEXT,    PC_START,   EM_PCT};
      5'd19: ucode = '{A_NONE, B_SCALE,  ACC_HOLD,     LD_NONE,    J_NEXT,    PC_START,   EM_USB};
      5'd20: ucode = '{A_MV_X, B_RCP_MV, ACC_HOLD,     LD_NONE,    J_NEXT,    PC_START,   EM_NONE};
      5'd21: ucode = '{A_NONE, B_SCALE,  ACC_HOLD,     LD_NONE,    J_NEXT,    PC_START,   EM_INVALID};
      default: ucode = '{A_NONE, B_SCALE, ACC_HOLD,    LD_NONE,    J_NEXT,    PC_START,   EM_NONE};
    endcase
  endfunction

endpackage

// ===== hdl/bvg_if.sv =====
// Valid/ready channels of the battery voltage gauge.
interface bvg_in_if #(parameter int ADC_BITS = 12) ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_count;

  modport source (output valid, output adc_count, input ready);
  modport sink   (input valid, input adc_count, output ready);
endinterface

interface bvg_out_if import bvg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_adc;
  logic [MV_W-1:0]  voltage_mv;
  logic             reading_valid;
  logic             on_usb_power;
  logic [PCT_W-1:0] percent;
  logic             pct_valid;

  modport source (output valid, output raw_adc, output voltage_mv, output reading_valid,
                  output on_usb_power, output percent, output pct_valid, input ready);
  modport sink   (input valid, input raw_adc, input voltage_mv, input reading_valid,
                  input on_usb_power, input percent, input pct_valid, output ready);
endinterface

// ===== hdl/battery_voltage_gauge.sv =====
// Battery voltage gauge: one ADC reading in, one voltage/percent result out.
// Each request is run by a small microcode program over one shared 32x32 multiplier
// with a registered product and an accumulator; a reading that fails the range checks
// takes the shortest path, one whose filtered voltage is at or above the USB threshold
// skips the percent curve, and the rest evaluate the curve; seeding either filter
// shortens its path. The multiplier does every product in turn (scaling, divisions
// by 1000 through reciprocals, both filters, the curve interpolation). A new request
// is taken the cycle after the result is loaded into the output register, even while
// that result still waits to be taken; a full output register stalls the program on
// its last step. Configuration writes land at once and are meant for idle.

`include "battery_voltage_gauge_assert.svh"

module battery_voltage_gauge import bvg_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  bvg_in_if.sink           in_ch,
  bvg_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int UV_W = ADC_BITS + SCALE_W;

  // sequencer
  logic                busy_r, busy_nxt;
  pc_t                 pc_r, pc_nxt;
  uword_t              uw;
  logic                step_en, emit_fire, take, in_acc;

  // datapath
  logic [ADC_BITS-1:0] adc_r, adc_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [UV_W-1:0]     uv_r, uv_nxt;
  logic [VQ8_W-1:0]    vq8_r, vq8_nxt;
  logic [SEG_W-1:0]    seg_r, seg_nxt;
  logic [T_W-1:0]      t_r, t_nxt;
  logic [PCT_W-1:0]    rawp_r, rawp_nxt;

  // gauge state and configuration
  logic [SV_W-1:0]     sv_r, sv_nxt;
  logic [SP_W-1:0]     sp_r, sp_nxt;
  logic                seeded_r, seeded_nxt;
  logic [PCT_W-1:0]    held_r, held_nxt;
  logic                held_v_r, held_v_nxt;
  logic [SCALE_W-1:0]  scale_r, scale_nxt;
  logic [USB_W-1:0]    usb_r, usb_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  res_t                res_r, res_nxt;

  // combinational helpers
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [UVX_W-1:0]    uv_ext, x_mv;
  logic [30:0]         x_q8;
  logic                uv_sat, c_invalid, c_vseed, c_usb, c_pseed, taken;
  logic [SEG_W-1:0]    seg_c;
  logic [SV_W-1:0]     lo_c;
  logic [15:0]         y_c;
  logic [20:0]         n_c;
  logic [SV_W:0]       mv_sum;
  logic [14:0]         mv_q;
  logic [MV_W-1:0]     mv_filt;
  logic [SP_W:0]       pct_sum;
  logic [7:0]          pct_q;
  logic [PCT_W-1:0]    pct_c;

  assign in_acc      = in_ch.valid && !busy_r;
  assign in_ch.ready = !busy_r;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.raw_adc       = res_r.raw_adc;
  assign out_ch.voltage_mv    = res_r.voltage_mv;
  assign out_ch.reading_valid = res_r.reading_valid;
  assign out_ch.on_usb_power  = res_r.on_usb_power;
  assign out_ch.percent       = res_r.percent;
  assign out_ch.pct_valid     = res_r.pct_valid;

  always_comb begin
    uw = ucode(pc_r);

    // a step that emits waits for a free output register
    take      = !out_valid_r || out_ch.ready;
    step_en   = busy_r && ((uw.emit == EM_NONE) || take);
    emit_fire = step_en && (uw.emit != EM_NONE);

    // microvolt views of the scaled reading
    uv_ext = UVX_W'(uv_r);
    x_mv   = uv_ext + UV_RND;
    x_q8   = {uv_ext[22:0], 8'd0} + UVQ8_RND;
    uv_sat = uv_ext >= UV_SAT;

    // branch conditions
    c_invalid = (adc_r <= ADC_BITS'(ADC_MIN)) || (uv_ext < UV_MIN) || (uv_ext > UV_MAX);
    c_vseed   = sv_r <= SV_SEED_MAX;
    c_usb     = sv_r >= {usb_r, 8'd0};
    c_pseed   = !seeded_r;
    case (uw.jmp)
      J_NEXT:    taken = 1'b0;
      J_ALWAYS:  taken = 1'b1;
      J_INVALID: taken = c_invalid;
      J_VSEED:   taken = c_vseed;
      J_USB:     taken = c_usb;
      J_PSEED:   taken = c_pseed;
      default:   taken = 1'b0;
    endcase

    // curve segment: first knot at or below the filtered voltage
    seg_c = SEG_W'(NSEG - 1);
    for (int i = NSEG - 1; i >= 0; i--) begin
      if (sv_r >= {1'b0, SEG_LO_MV[i], 8'd0}) seg_c = SEG_W'(i);
    end
    lo_c = {1'b0, SEG_LO_MV[seg_c], 8'd0};
    y_c  = 16'(sv_r - lo_c);
    // round(10*y / (256*span)) = floor(t / span), t = (20*y + 256*span) >> 9
    n_c  = 21'(y_c) * 21'd20 + 21'({SEG_SPAN[seg_c], 8'd0});

    // multiplier operands
    case (uw.a)
      A_ADC:   mul_a = MUL_W'(adc_r);
      A_MV_X:  mul_a = MUL_W'(x_mv[23:0]);
      A_Q8_X:  mul_a = MUL_W'(x_q8);
      A_SV:    mul_a = MUL_W'(sv_r);
      A_VQ8:   mul_a = MUL_W'(vq8_r);
      A_T:     mul_a = MUL_W'(t_r);
      A_SP:    mul_a = MUL_W'(sp_r);
      A_RAWP:  mul_a = MUL_W'(rawp_r);
      default: mul_a = '0;
    endcase
    case (uw.b)
      B_SCALE:  mul_b = MUL_W'(scale_r);
      B_RCP_MV: mul_b = RCP_MV;
      B_RCP_Q8: mul_b = RCP_Q8;
      B_VA_OLD: mul_b = VA_OLD;
      B_VA_NEW: mul_b = VA_NEW;
      B_PA_OLD: mul_b = PA_OLD;
      B_PA_NEW: mul_b = PA_NEW_Q8;
      B_SEG:    mul_b = MUL_W'(SEG_RCP[seg_r]);
      default:  mul_b = '0;
    endcase

    // rounded outputs
    mv_sum  = {1'b0, sv_r} + 23'd128;
    mv_q    = mv_sum[22:8];
    mv_filt = (mv_q > 15'(MV_MAX)) ? MV_MAX : mv_q[13:0];
    pct_sum = {1'b0, sp_r} + 16'd128;
    pct_q   = pct_sum[15:8];
    pct_c   = (pct_q > 8'(PCT_FULL)) ? PCT_FULL : pct_q[6:0];

    // defaults
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    adc_nxt       = adc_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    uv_nxt        = uv_r;
    vq8_nxt       = vq8_r;
    seg_nxt       = seg_r;
    t_nxt         = t_r;
    rawp_nxt      = rawp_r;
    sv_nxt        = sv_r;
    sp_nxt        = sp_r;
    seeded_nxt    = seeded_r;
    held_nxt      = held_r;
    held_v_nxt    = held_v_r;
    scale_nxt     = scale_r;
    usb_nxt       = usb_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_SCALE: scale_nxt = cfg_data[SCALE_W-1:0];
        CFG_IDX_USB:   usb_nxt   = cfg_data[USB_W-1:0];
        default: ;
      endcase
    end

    if (in_acc) begin
      busy_nxt = 1'b1;
      pc_nxt   = PC_START;
      adc_nxt  = in_ch.adc_count;
    end

    if (step_en) begin
      if (uw.a != A_NONE) prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

      case (uw.acc)
        ACC_LOAD_RND: acc_nxt = prod_r[ACC_W-1:0] + ACC_RND;
        ACC_ADD:      acc_nxt = acc_r + prod_r[ACC_W-1:0];
        default: ;
      endcase

      case (uw.ld)
        LD_UV:      uv_nxt  = prod_r[UV_W-1:0];
        LD_VQ8:     vq8_nxt = prod_r[41 +: VQ8_W];
        LD_SV_ACC:  sv_nxt  = acc_r[16 +: SV_W];
        LD_SV_VQ8:  sv_nxt  = SV_W'(vq8_r);
        LD_T: begin
          seg_nxt = seg_c;
          t_nxt   = n_c[20:9];
        end
        LD_RAWP: begin
          if (sv_r >= {1'b0, MV_FULL, 8'd0}) begin
            rawp_nxt = PCT_FULL;
          end else if (sv_r <= {1'b0, MV_EMPTY, 8'd0}) begin
            rawp_nxt = PCT_EMPTY;
          end else begin
            rawp_nxt = SEG_LO_PC[seg_r] + PCT_W'(prod_r[27:24]);
          end
        end
        LD_SP_ACC:  sp_nxt = acc_r[16 +: SP_W];
        LD_SP_SEED: begin
          sp_nxt     = {rawp_r, 8'd0};
          seeded_nxt = 1'b1;
        end
        default: ;
      endcase

      case (uw.emit)
        EM_INVALID: begin
          res_nxt.voltage_mv    = uv_sat ? MV_MAX : prod_r[34 +: MV_W];
          res_nxt.reading_valid = 1'b0;
          res_nxt.on_usb_power  = 1'b0;
          res_nxt.percent       = PCT_EMPTY;
          res_nxt.pct_valid     = 1'b0;
        end
        EM_USB: begin
          res_nxt.voltage_mv    = mv_filt;
          res_nxt.reading_valid = 1'b1;
          res_nxt.on_usb_power  = 1'b1;
          res_nxt.percent       = held_v_r ? held_r : PCT_EMPTY;
          res_nxt.pct_valid     = held_v_r;
        end
        EM_PCT: begin
          res_nxt.voltage_mv    = mv_filt;
          res_nxt.reading_valid = 1'b1;
          res_nxt.on_usb_power  = 1'b0;
          res_nxt.percent       = pct_c;
          res_nxt.pct_valid     = 1'b1;
          held_nxt              = pct_c;
          held_v_nxt            = 1'b1;
        end
        default: ;
      endcase

      if (emit_fire) begin
        // echo only when loading, a waiting result keeps its own reading
        res_nxt.raw_adc = RAW_W'(adc_r);
        busy_nxt      = 1'b0;
        pc_nxt        = PC_START;
        out_valid_nxt = 1'b1;
      end else begin
        pc_nxt = taken ? uw.target : pc_t'(pc_r + 5'd1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_START;
      out_valid_r <= 1'b0;
      sv_r        <= '0;
      sp_r        <= '0;
      seeded_r    <= 1'b0;
      held_r      <= '0;
      held_v_r    <= 1'b0;
      scale_r     <= SCALE_RST;
      usb_r       <= USB_RST;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      sv_r        <= sv_nxt;
      sp_r        <= sp_nxt;
      seeded_r    <= seeded_nxt;
      held_r      <= held_nxt;
      held_v_r    <= held_v_nxt;
      scale_r     <= scale_nxt;
      usb_r       <= usb_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    adc_r  <= adc_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    uv_r   <= uv_nxt;
    vq8_r  <= vq8_nxt;
    seg_r  <= seg_nxt;
    t_r    <= t_nxt;
    rawp_r <= rawp_nxt;
    res_r  <= res_nxt;
  end

  `BVG_ASSERT_NEXT(a_start, in_acc, busy_r && (pc_r == PC_START), "request did not start program")
  `BVG_ASSERT_IMPLY(a_pc_range, busy_r, pc_r <= PC_LAST, "sequencer left the program")
  `BVG_ASSERT_NEXT(a_held_sticky, held_v_r, held_v_r, "held percent lost its valid flag")
  `BVG_ASSERT_IMPLY(a_pct_ok, out_valid_r && res_r.pct_valid, res_r.reading_valid && (res_r.percent <= PCT_FULL), "percent result out of range")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the battery voltage gauge: directed cases, then random readings.
module testbench import bvg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADC_BITS = 12;

  // Q16 filter weights and the range window in microvolts
  localparam longint unsigned VOLT_KEEP = 55706;
  localparam longint unsigned VOLT_TAKE = 9830;
  localparam longint unsigned PCT_KEEP  = 58982;
  localparam longint unsigned PCT_TAKE  = 6554;
  localparam longint unsigned HALF_Q16  = 32768;
  localparam longint unsigned UV_FLOOR  = 500000;
  localparam longint unsigned UV_CEIL   = 6500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic recv_ready = 1'b0;

  bvg_in_if #(.ADC_BITS(ADC_BITS)) in_ch ();
  bvg_out_if out_ch ();

  assign out_ch.ready = recv_ready;

  battery_voltage_gauge #(.ADC_BITS(ADC_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gauge state as the block should hold it, starting from the reset values.
  logic [SCALE_W-1:0] scale_uv       = SCALE_RST;
  logic [USB_W-1:0]   usb_thr_mv     = USB_RST;
  logic [SV_W-1:0]    volt_avg_q8    = '0;
  logic [SP_W-1:0]    pct_avg_q8     = '0;
  logic               pct_seeded     = 1'b0;
  logic [PCT_W-1:0]   held_pct       = '0;
  logic               held_pct_valid = 1'b0;

  res_t gauge_results[$];     // expected results, oldest first
  int unsigned mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int battery_level_mv = 4000; // random walk of the simulated cell voltage

  // Discharge curve knots, high to low.
  function automatic longint unsigned knee_mv(input int i);
    case (i)
      0: knee_mv = 4200;  1: knee_mv = 4100;  2: knee_mv = 4000;  3: knee_mv = 3920;
      4: knee_mv = 3850;  5: knee_mv = 3790;  6: knee_mv = 3740;  7: knee_mv = 3680;
      8: knee_mv = 3600;  9: knee_mv = 3500;  default: knee_mv = 3350;
    endcase
  endfunction

  function automatic longint unsigned knee_pct(input int i);
    knee_pct = (i >= 10) ? 0 : longint'(100 - 10 * i);
  endfunction

  // Percent from a Q8 millivolt value, linear between knots, rounding half up.
  function automatic int unsigned curve_percent_of(input longint unsigned v_q8);
    longint unsigned hi, lo, num, den;
    if (v_q8 >= knee_mv(0) * 256) return 100;
    if (v_q8 <= knee_mv(10) * 256) return 0;
    for (int i = 0; i < 10; i++) begin
      hi = knee_mv(i) * 256;
      lo = knee_mv(i + 1) * 256;
      if (v_q8 <= hi && v_q8 >= lo) begin
        num = (knee_pct(i) - knee_pct(i + 1)) * (v_q8 - lo);
        den = hi - lo;
        return int'(knee_pct(i + 1) + (2 * num + den) / (2 * den));
      end
    end
    return 0;
  endfunction

  // Works out the result of one accepted reading and advances the gauge state.
  function automatic res_t predict_gauge_reading(input logic [ADC_BITS-1:0] adc);
    longint unsigned uv, v_q8, mv, acc;
    int unsigned raw_pct, pct;
    res_t r;
    r = '0;
    r.raw_adc = adc;
    uv = 64'(adc) * 64'(scale_uv);
    if (adc <= 10 || uv < UV_FLOOR || uv > UV_CEIL) begin
      // rejected: unfiltered voltage only, state left alone
      mv = (uv + 500) / 1000;
      if (mv > 16383) mv = 16383;
      r.voltage_mv = mv[MV_W-1:0];
      return r;
    end
    v_q8 = (uv * 256 + 500) / 1000;
    if (volt_avg_q8 <= 25) begin
      volt_avg_q8 = v_q8[SV_W-1:0];
    end else begin
      acc = (64'(volt_avg_q8) * VOLT_KEEP + v_q8 * VOLT_TAKE + HALF_Q16) >> 16;
      volt_avg_q8 = acc[SV_W-1:0];
    end
    mv = (64'(volt_avg_q8) + 128) >> 8;
    if (mv > 16383) mv = 16383;
    r.voltage_mv = mv[MV_W-1:0];
    r.reading_valid = 1'b1;
    if (64'(volt_avg_q8) >= 64'(usb_thr_mv) * 256) begin
      r.on_usb_power = 1'b1;
      r.pct_valid = held_pct_valid;
      r.percent = held_pct_valid ? held_pct : '0;
      return r;
    end
    raw_pct = curve_percent_of(64'(volt_avg_q8));
    if (!pct_seeded) begin
      pct_avg_q8 = SP_W'(raw_pct * 256);
      pct_seeded = 1'b1;
    end else begin
      acc = (64'(pct_avg_q8) * PCT_KEEP + 64'(raw_pct) * 256 * PCT_TAKE + HALF_Q16) >> 16;
      pct_avg_q8 = acc[SP_W-1:0];
    end
    pct = (32'(pct_avg_q8) + 128) >> 8;
    if (pct > 100) pct = 100;
    held_pct = pct[PCT_W-1:0];
    held_pct_valid = 1'b1;
    r.percent = pct[PCT_W-1:0];
    r.pct_valid = 1'b1;
    return r;
  endfunction

  // All driving tasks start and end at a falling edge.
  task automatic send_reading(input logic [ADC_BITS-1:0] adc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.adc_count = adc;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    gauge_results.push_back(predict_gauge_reading(adc));
    @(negedge clk);
  endtask

  // Hold off new requests until every expected result has been taken.
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (gauge_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [0:0] idx, input logic [CFG_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_IDX_SCALE) scale_uv = value[SCALE_W-1:0];
    else usb_thr_mv = value[USB_W-1:0];
  endtask

  // Mostly a plausible cell voltage that drifts; a fifth of readings are arbitrary counts.
  task automatic send_random_reading();
    logic [ADC_BITS-1:0] adc;
    longint unsigned count;
    if ($urandom_range(99) < 20 || scale_uv == 0) begin
      adc = ADC_BITS'($urandom_range(4095));
    end else begin
      if ($urandom_range(99) < 8) battery_level_mv = int'($urandom_range(4700, 3000));
      else battery_level_mv += int'($urandom_range(40)) - 20;
      if (battery_level_mv < 3000) battery_level_mv = 3000;
      if (battery_level_mv > 4800) battery_level_mv = 4800;
      count = (64'(battery_level_mv) * 1000 + scale_uv / 2) / scale_uv;
      if (count > 4095) count = 4095;
      adc = count[ADC_BITS-1:0];
    end
    send_reading(adc);
  endtask

  // Readings at or below ten counts and tiny voltages are rejected.
  task automatic test_rejected_readings();
    send_reading(0);
    send_reading(10);
    send_reading(11);
  endtask

  // First valid reading seeds the voltage filter above the USB threshold: no percent yet.
  task automatic test_usb_without_history();
    send_reading(2000);
    send_reading(2520);   // just inside the upper window
    send_reading(2521);   // just outside
    send_reading(193);    // just below the lower window
    send_reading(194);
    wait_drained();
  endtask

  // Exact window edges in microvolts.
  task automatic test_range_bounds();
    write_register(CFG_IDX_SCALE, 14'd2500);
    send_reading(199);
    send_reading(200);    // exactly 0.5 V
    send_reading(2600);   // exactly 6.5 V
    send_reading(2601);
    wait_drained();
  endtask

  // Upper scale bits beyond the register width are dropped; rejected voltage saturates.
  task automatic test_scale_saturation();
    write_register(CFG_IDX_SCALE, 14'h3FFF);
    send_reading(4095);
    send_reading(122);
    send_reading(123);
    wait_drained();
  endtask

  // Pull the filtered voltage through the curve to the empty end and back up.
  task automatic test_percent_curve();
    write_register(CFG_IDX_SCALE, 14'd2579);
    write_register(CFG_IDX_USB, 14'd16383);
    repeat (4) send_reading(194);
    repeat (2) send_reading(1629);
    wait_drained();
  endtask

  // Threshold zero: always on USB, reporting the held percent.
  task automatic test_usb_with_history();
    write_register(CFG_IDX_USB, 14'd0);
    send_reading(1000);
    wait_drained();
  endtask

  task automatic run_random_phase(input int n_items, input int send_pct, input int recv_pct,
                                  input bit pause_midway);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      if (pause_midway && i == n_items / 2) wait_drained();
      send_random_reading();
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    write_register(CFG_IDX_SCALE, 14'd2579);
    write_register(CFG_IDX_USB, 14'd4000);
    run_random_phase(150, 23, 71, 1'b1);
    // zero scale: every reading reads as 0 V and is rejected
    write_register(CFG_IDX_SCALE, 14'd0);
    run_random_phase(8, 23, 71, 1'b0);
    write_register(CFG_IDX_SCALE, 14'd4000);
    write_register(CFG_IDX_USB, 14'd4300);
    run_random_phase(150, 71, 23, 1'b0);
    write_register(CFG_IDX_SCALE, 14'd1200);
    write_register(CFG_IDX_USB, 14'd16383);
    run_random_phase(150, 0, 0, 1'b0);
  endtask

  // Result ready toggles at the falling edge.
  always @(negedge clk) begin
    recv_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic compare_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Every taken result is checked against the oldest expectation.
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (gauge_results.size() == 0) begin
        $error("result with raw_adc %0d arrived with nothing expected", out_ch.raw_adc);
        mismatch_count++;
      end else begin
        want = gauge_results.pop_front();
        compare_field("raw_adc", 32'(want.raw_adc), 32'(out_ch.raw_adc));
        compare_field("voltage_mv", 32'(want.voltage_mv), 32'(out_ch.voltage_mv));
        compare_field("reading_valid", 32'(want.reading_valid), 32'(out_ch.reading_valid));
        compare_field("on_usb_power", 32'(want.on_usb_power), 32'(out_ch.on_usb_power));
        compare_field("percent", 32'(want.percent), 32'(out_ch.percent));
        compare_field("pct_valid", 32'(want.pct_valid), 32'(out_ch.pct_valid));
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.adc_count = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_IDX_SCALE;
    cfg_data = '0;
    // synchronous reset, released at a falling edge
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part runs with the first idling mix
    send_idle_pct = 23;
    recv_idle_pct = 71;
    test_rejected_readings();
    test_usb_without_history();
    test_range_bounds();
    test_scale_saturation();
    test_percent_curve();
    test_usb_with_history();
    test_random_traffic();

    wait_drained();
    repeat (20) @(negedge clk);
    if (gauge_results.size() != 0) begin
      $error("%0d expected results never arrived", gauge_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
